>>> hw/rtl/salrc_pkg.sv
package salrc_pkg;

	localparam int ADDR_W     = 9;
	localparam int WORD_W     = 32;
	localparam int STAMP_W    = 32;
	localparam int COUNT_W    = 32;
	localparam int LINE_BYTES = 8;
	localparam int LINE_W     = LINE_BYTES * 8;
	localparam int OFFSET_W   = $clog2(LINE_BYTES);
	localparam int BLOCK_W    = ADDR_W - OFFSET_W;
	localparam int NUM_BLOCKS = 2 ** BLOCK_W;
	// word index taken from a byte address, before wrapping to the memory depth
	localparam int WIDX_IN_W  = ADDR_W - 2;
	localparam int NUM_WIDX   = 2 ** WIDX_IN_W;

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_BYTE = 2'd1;
	localparam logic [1:0] REQ_HALF = 2'd2;
	localparam logic [1:0] REQ_WORD = 2'd3;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [ADDR_W-1:0] address;
		logic [WORD_W-1:0] load_word;
	} cache_req_t;

	typedef struct packed {
		logic                     hit;
		logic signed [WORD_W-1:0] read_value;
		logic                     misaligned;
		logic [COUNT_W-1:0]       bytes_total;
	} cache_rsp_t;

	typedef struct packed {
		logic hit;
		logic last;
	} scan_stat_t;

endpackage

>>> hw/rtl/salrc_scan.sv
module salrc_scan #(
	parameter int NUM_WAYS = 2,
	parameter int TAG_W    = 4,
	parameter int WAY_W    = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           step,
	input  logic                           entry_valid,
	input  logic [TAG_W-1:0]               entry_tag,
	input  logic [salrc_pkg::STAMP_W-1:0]  entry_stamp,
	input  logic [TAG_W-1:0]               req_tag,
	output logic [WAY_W-1:0]               way,
	output logic [WAY_W-1:0]               victim_next,
	output salrc_pkg::scan_stat_t          stat
);

	logic [WAY_W-1:0]              way_q;
	logic [WAY_W-1:0]              vic_q;
	logic                          have_inv_q;
	logic [salrc_pkg::STAMP_W-1:0] best_q;
	logic                          take_inv;
	logic                          take_old;

	assign way       = way_q;
	assign stat.hit  = entry_valid && (entry_tag == req_tag);
	assign stat.last = (way_q == WAY_W'(NUM_WAYS - 1));

	// first invalid way wins outright; otherwise strictly older stamp, lowest way on ties
	assign take_inv    = !entry_valid && !have_inv_q;
	assign take_old    = entry_valid && !have_inv_q &&
		((way_q == '0) || (entry_stamp < best_q));
	assign victim_next = (take_inv || take_old) ? way_q : vic_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			way_q      <= '0;
			vic_q      <= '0;
			have_inv_q <= 1'b0;
			best_q     <= '0;
		end else if (start) begin
			way_q      <= '0;
			vic_q      <= '0;
			have_inv_q <= 1'b0;
		end else if (step) begin
			if (take_inv) begin
				have_inv_q <= 1'b1;
			end
			if (take_old) begin
				best_q <= entry_stamp;
			end
			vic_q <= victim_next;
			if (!stat.last) begin
				way_q <= way_q + 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/set_assoc_lru_read_cache_unit.sv
// Read-only set-associative cache, 8-byte lines, LRU by access stamp, over a word memory.
// Request channel (req_valid/req_ready, payload req): load a memory word, or read a
// byte, halfword or word at a byte address. Response channel (rsp_valid/rsp_ready,
// payload rsp): one response per request with hit, sign-extended data, misaligned
// flag and running byte count.
// One request is in flight at a time; req_ready is high only while the sequencer is idle.
// States from acceptance to rsp_valid (S_RESP waits for a free output register):
//   load or misaligned read: S_RESP
//   read hit in way k:       S_SCAN, S_FINISH, S_RESP (ways are checked one per cycle)
//   read miss:               full way scan, two memory word reads, S_FINISH, S_RESP
// The way scan shares one tag/stamp compare unit; the miss fill is set by the
// single-port backing memory, one word per cycle.
// The response sits in an output register; a stalled receiver holds the block in its
// final state, and a new request is taken once the sequencer returns to idle.
// Reset clears the valid state of every set at once (per-set init flags); no sweep
// is needed and requests are taken as soon as reset is released. Backing memory
// holds no reset value: a fill from a never-loaded word returns unspecified data.
module set_assoc_lru_read_cache_unit #(
	parameter int NUM_SETS  = 4,
	parameter int NUM_WAYS  = 2,
	parameter int MEM_WORDS = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  salrc_pkg::cache_req_t req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output salrc_pkg::cache_rsp_t rsp
);

	localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int MAX_TAG = (salrc_pkg::NUM_BLOCKS - 1) / NUM_SETS;
	localparam int TAG_W   = (MAX_TAG > 0) ? $clog2(MAX_TAG + 1) : 1;
	localparam int MIDX_W  = $clog2(MEM_WORDS);
	localparam int LINE_W  = salrc_pkg::LINE_W;
	localparam int WORD_W  = salrc_pkg::WORD_W;
	localparam int OFF_W   = salrc_pkg::OFFSET_W;
	localparam int ADDR_W  = salrc_pkg::ADDR_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_FETCH0 = 3'd2;
	localparam logic [2:0] S_FETCH1 = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;
	localparam logic [2:0] S_RESP   = 3'd5;

	// address decode tables
	logic [SET_W-1:0]  set_tab  [salrc_pkg::NUM_BLOCKS];
	logic [TAG_W-1:0]  tag_tab  [salrc_pkg::NUM_BLOCKS];
	logic [MIDX_W-1:0] widx_tab [salrc_pkg::NUM_WIDX];

	for (genvar gb = 0; gb < salrc_pkg::NUM_BLOCKS; gb++) begin : g_blk_tab
		assign set_tab[gb] = SET_W'(gb % NUM_SETS);
		assign tag_tab[gb] = TAG_W'(gb / NUM_SETS);
	end
	for (genvar gw = 0; gw < salrc_pkg::NUM_WIDX; gw++) begin : g_widx_tab
		assign widx_tab[gw] = MIDX_W'(gw % MEM_WORDS);
	end

	// storage
	logic [NUM_WAYS-1:0]                   valid_mem [NUM_SETS];
	logic [NUM_WAYS-1:0][TAG_W-1:0]        tag_mem   [NUM_SETS];
	logic [NUM_WAYS-1:0][salrc_pkg::STAMP_W-1:0] stamp_mem [NUM_SETS];
	logic [NUM_WAYS-1:0][LINE_W-1:0]       line_mem  [NUM_SETS];
	logic [WORD_W-1:0]                     back_mem  [MEM_WORDS];

	logic [2:0]                      state_q;
	logic                            rsp_valid_q;
	salrc_pkg::cache_rsp_t           rsp_q;
	salrc_pkg::cache_rsp_t           result_q;
	logic [NUM_SETS-1:0]             set_init_q;
	logic                            init_rd_q;
	logic [salrc_pkg::STAMP_W-1:0]   clock_q;
	logic [salrc_pkg::COUNT_W-1:0]   byte_cnt_q;
	logic [1:0]                      req_type_q;
	logic [ADDR_W-1:0]               addr_q;
	logic                            hit_q;
	logic [WAY_W-1:0]                sel_way_q;
	logic [WORD_W-1:0]               lo_q;
	logic [WORD_W-1:0]               mem_rd_q;
	logic [NUM_WAYS-1:0]             valid_rd_q;
	logic [NUM_WAYS-1:0][TAG_W-1:0]  tag_rd_q;
	logic [NUM_WAYS-1:0][salrc_pkg::STAMP_W-1:0] stamp_rd_q;
	logic [NUM_WAYS-1:0][LINE_W-1:0] line_rd_q;

	logic                            accept;
	logic                            slot_free;
	logic [salrc_pkg::BLOCK_W-1:0]   req_block;
	logic                            req_mis;
	logic                            req_read;
	logic [salrc_pkg::COUNT_W-1:0]   req_size;
	logic [salrc_pkg::BLOCK_W-1:0]   cur_block;
	logic [SET_W-1:0]                cur_set;
	logic [TAG_W-1:0]                cur_tag;
	logic [NUM_WAYS-1:0]             valid_eff;
	logic [NUM_WAYS-1:0]             valid_new;
	logic [NUM_WAYS-1:0][TAG_W-1:0]  tag_new;
	logic [NUM_WAYS-1:0][salrc_pkg::STAMP_W-1:0] stamp_new;
	logic [NUM_WAYS-1:0][LINE_W-1:0] line_new;
	logic [LINE_W-1:0]               fill_line;
	logic [LINE_W-1:0]               line_sel;
	logic [LINE_W-1:0]               line_shift;
	logic [WORD_W-1:0]               raw;
	logic [WORD_W-1:0]               rd_value;
	logic                            mem_re;
	logic [MIDX_W-1:0]               mem_raddr;
	logic                            row_re;
	logic                            row_we;
	logic [WAY_W-1:0]                scan_way;
	logic [WAY_W-1:0]                victim_next;
	salrc_pkg::scan_stat_t           scan_stat;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign req_block = req.address[ADDR_W-1:OFF_W];
	assign req_read  = (req.req_type != salrc_pkg::REQ_LOAD);
	assign req_mis   = ((req.req_type == salrc_pkg::REQ_HALF) && req.address[0]) ||
		((req.req_type == salrc_pkg::REQ_WORD) && (req.address[1:0] != 2'b00));

	always_comb begin
		unique case (req.req_type)
			salrc_pkg::REQ_BYTE: req_size = salrc_pkg::COUNT_W'(1);
			salrc_pkg::REQ_HALF: req_size = salrc_pkg::COUNT_W'(2);
			salrc_pkg::REQ_WORD: req_size = salrc_pkg::COUNT_W'(4);
			salrc_pkg::REQ_LOAD: req_size = '0;
		endcase
	end

	assign cur_block = addr_q[ADDR_W-1:OFF_W];
	assign cur_set   = set_tab[cur_block];
	assign cur_tag   = tag_tab[cur_block];

	// rows of a set never written since reset read as all ways invalid
	assign valid_eff = valid_rd_q & {NUM_WAYS{init_rd_q}};

	salrc_scan #(
		.NUM_WAYS (NUM_WAYS),
		.TAG_W    (TAG_W),
		.WAY_W    (WAY_W)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept),
		.step        (state_q == S_SCAN),
		.entry_valid (valid_eff[scan_way]),
		.entry_tag   (tag_rd_q[scan_way]),
		.entry_stamp (stamp_rd_q[scan_way]),
		.req_tag     (cur_tag),
		.way         (scan_way),
		.victim_next (victim_next),
		.stat        (scan_stat)
	);

	assign fill_line = {mem_rd_q, lo_q};
	assign line_sel  = hit_q ? line_rd_q[sel_way_q] : fill_line;

	always_comb begin
		valid_new            = valid_eff;
		valid_new[sel_way_q] = 1'b1;
		tag_new              = tag_rd_q;
		tag_new[sel_way_q]   = cur_tag;
		stamp_new            = stamp_rd_q;
		stamp_new[sel_way_q] = clock_q;
		line_new             = line_rd_q;
		line_new[sel_way_q]  = line_sel;
	end

	assign line_shift = line_sel >> {addr_q[OFF_W-1:0], 3'b000};
	assign raw        = line_shift[WORD_W-1:0];

	always_comb begin
		unique case (req_type_q)
			salrc_pkg::REQ_BYTE: rd_value = {{(WORD_W - 8){raw[7]}}, raw[7:0]};
			salrc_pkg::REQ_HALF: rd_value = {{(WORD_W - 16){raw[15]}}, raw[15:0]};
			salrc_pkg::REQ_WORD: rd_value = raw;
			salrc_pkg::REQ_LOAD: rd_value = '0;
		endcase
	end

	assign row_re    = accept && req_read && !req_mis;
	assign row_we    = (state_q == S_FINISH);
	assign mem_re    = (state_q == S_FETCH0) || (state_q == S_FETCH1);
	assign mem_raddr = widx_tab[{cur_block, (state_q == S_FETCH1)}];

	always_ff @(posedge clk) begin
		if (row_we) begin
			valid_mem[cur_set] <= valid_new;
			tag_mem[cur_set]   <= tag_new;
			stamp_mem[cur_set] <= stamp_new;
			line_mem[cur_set]  <= line_new;
		end
		if (row_re) begin
			valid_rd_q <= valid_mem[set_tab[req_block]];
			tag_rd_q   <= tag_mem[set_tab[req_block]];
			stamp_rd_q <= stamp_mem[set_tab[req_block]];
			line_rd_q  <= line_mem[set_tab[req_block]];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !req_read) begin
			back_mem[widx_tab[req.address[ADDR_W-1:2]]] <= req.load_word;
		end
		if (mem_re) begin
			mem_rd_q <= back_mem[mem_raddr];
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			set_init_q  <= '0;
			init_rd_q   <= 1'b0;
			clock_q     <= '0;
			byte_cnt_q  <= '0;
		end else begin
			// in S_RESP the response register is reloaded below instead
			if (rsp_valid_q && rsp_ready && (state_q != S_RESP)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_read && !req_mis) begin
							init_rd_q  <= set_init_q[set_tab[req_block]];
							clock_q    <= clock_q + 1'b1;
							byte_cnt_q <= byte_cnt_q + req_size;
							state_q    <= S_SCAN;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_SCAN: begin
					if (scan_stat.hit) begin
						state_q <= S_FINISH;
					end else if (scan_stat.last) begin
						state_q <= S_FETCH0;
					end
				end
				S_FETCH0: state_q <= S_FETCH1;
				S_FETCH1: state_q <= S_FINISH;
				S_FINISH: begin
					set_init_q[cur_set] <= 1'b1;
					state_q             <= S_RESP;
				end
				S_RESP: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q           <= req.req_type;
			addr_q               <= req.address;
			result_q.hit         <= 1'b0;
			result_q.read_value  <= '0;
			result_q.misaligned  <= req_mis;
			result_q.bytes_total <= byte_cnt_q;
		end
		if (state_q == S_SCAN) begin
			hit_q     <= scan_stat.hit;
			sel_way_q <= scan_stat.hit ? scan_way : victim_next;
		end
		if (state_q == S_FETCH1) begin
			lo_q <= mem_rd_q;
		end
		if (state_q == S_FINISH) begin
			result_q.hit         <= hit_q;
			result_q.read_value  <= rd_value;
			result_q.misaligned  <= 1'b0;
			result_q.bytes_total <= byte_cnt_q;
		end
		if ((state_q == S_RESP) && slot_free) begin
			rsp_q <= result_q;
		end
	end

endmodule

>>> hw/rtl/salrc_checker.sv
module salrc_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input salrc_pkg::cache_rsp_t rsp
);

	// one request in flight: the block goes busy right after taking one
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req_ready still high after a request was taken");

	a_mis_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.misaligned |-> !rsp.hit && (rsp.read_value == 0))
		else $error("misaligned response carries hit or data");

	// a new response only comes out of a busy block
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("response appeared while block was idle");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response dropped or changed");

endmodule

bind set_assoc_lru_read_cache_unit salrc_checker u_salrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int SETS        = 4;
	localparam int WAYS        = 2;
	localparam int MEM_DEPTH   = 128;
	localparam int LINES       = SETS * WAYS;
	localparam int RANDOM_REQS = 1150;
	localparam int SETTLE      = 16;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		salrc_pkg::cache_req_t rq;
		bit                    typed;
		salrc_pkg::cache_rsp_t rsp;
	} stim_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  rsp_ready = 1'b0;
	salrc_pkg::cache_req_t req       = '0;
	logic                  req_ready;
	logic                  rsp_valid;
	salrc_pkg::cache_rsp_t rsp;

	// mirror of the cache contents and counters
	bit          line_valid [LINES];
	int          line_tag   [LINES];
	logic [31:0] line_stamp [LINES];
	logic [63:0] line_data  [LINES];
	logic [31:0] mem_image  [MEM_DEPTH];
	logic [31:0] access_clock;
	logic [31:0] byte_count;

	salrc_pkg::cache_rsp_t owed_rsp[$];
	stim_row_t             stim_rows[$];
	int                    sent_count = 0;
	int                    rsp_count  = 0;
	int                    err_count  = 0;
	int                    cycle_count = 0;

	set_assoc_lru_read_cache_unit #(
		.NUM_SETS (SETS),
		.NUM_WAYS (WAYS),
		.MEM_WORDS(MEM_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic salrc_pkg::cache_rsp_t cache_lookup(input salrc_pkg::cache_req_t r);
		salrc_pkg::cache_rsp_t o;
		int                    sz, blk, set_i, tg, off, base, w, victim;
		bit                    found;
		logic [63:0]           ln;
		logic [31:0]           raw;
		o = '0;
		if (r.req_type == salrc_pkg::REQ_LOAD) begin
			mem_image[(r.address >> 2) % MEM_DEPTH] = r.load_word;
			o.bytes_total = byte_count;
			return o;
		end
		sz = (r.req_type == salrc_pkg::REQ_BYTE) ? 1 :
			(r.req_type == salrc_pkg::REQ_HALF) ? 2 : 4;
		if ((r.address & (sz - 1)) != 0) begin
			o.misaligned  = 1'b1;
			o.bytes_total = byte_count;
			return o;
		end
		blk   = r.address / salrc_pkg::LINE_BYTES;
		off   = r.address % salrc_pkg::LINE_BYTES;
		set_i = blk % SETS;
		tg    = blk / SETS;
		base  = set_i * WAYS;
		access_clock = access_clock + 32'd1;
		found  = 1'b0;
		victim = 0;
		for (w = 0; w < WAYS; w++) begin
			if (!found && line_valid[base + w] && line_tag[base + w] == tg) begin
				found  = 1'b1;
				victim = w;
			end
		end
		if (!found) begin
			// lowest invalid way first, else oldest stamp with the lowest way on ties
			victim = -1;
			for (w = 0; w < WAYS; w++)
				if (victim < 0 && !line_valid[base + w])
					victim = w;
			if (victim < 0) begin
				victim = 0;
				for (w = 1; w < WAYS; w++)
					if (line_stamp[base + w] < line_stamp[base + victim])
						victim = w;
			end
			line_data[base + victim]  = {mem_image[(blk * 2 + 1) % MEM_DEPTH],
				mem_image[(blk * 2) % MEM_DEPTH]};
			line_valid[base + victim] = 1'b1;
			line_tag[base + victim]   = tg;
		end
		line_stamp[base + victim] = access_clock;
		ln  = line_data[base + victim] >> (off * 8);
		raw = ln[31:0];
		case (r.req_type)
			salrc_pkg::REQ_BYTE: raw = {{24{raw[7]}}, raw[7:0]};
			salrc_pkg::REQ_HALF: raw = {{16{raw[15]}}, raw[15:0]};
			default:             raw = raw;
		endcase
		byte_count    = byte_count + sz;
		o.hit         = found;
		o.read_value  = raw;
		o.bytes_total = byte_count;
		return o;
	endfunction

	// quiet stretches with no idling every fourth block of requests
	function automatic int draw_gap(input int idx);
		if ((idx / 120) % 4 == 3)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	task automatic add_row(input logic [1:0] kind, input int addr, input logic [31:0] data,
		input bit typed, input logic e_hit, input logic [31:0] e_val, input logic e_mis,
		input logic [31:0] e_total);
		stim_row_t row;
		row.rq.req_type      = kind;
		row.rq.address       = addr[salrc_pkg::ADDR_W-1:0];
		row.rq.load_word     = data;
		row.typed            = typed;
		row.rsp.hit          = e_hit;
		row.rsp.read_value   = e_val;
		row.rsp.misaligned   = e_mis;
		row.rsp.bytes_total  = e_total;
		stim_rows.push_back(row);
	endtask

	// entered and left at a falling edge
	task automatic send_req(input salrc_pkg::cache_req_t item, input bit typed,
		input salrc_pkg::cache_rsp_t typed_rsp);
		int                    gap;
		salrc_pkg::cache_rsp_t pred;
		gap = draw_gap(sent_count);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		pred = cache_lookup(item);
		owed_rsp.push_back(typed ? typed_rsp : pred);
		sent_count++;
		@(negedge clk);
	endtask

	initial begin : rsp_sink
		int                    stall;
		salrc_pkg::cache_rsp_t exp_rsp;
		bit                    bad;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = draw_gap(rsp_count);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!(rsp_valid && rsp_ready));
			rsp_count++;
			if (owed_rsp.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected response: hit %0b value %h mis %0b total %0d",
						rsp.hit, rsp.read_value, rsp.misaligned, rsp.bytes_total);
			end else begin
				exp_rsp = owed_rsp.pop_front();
				bad = (rsp.hit !== exp_rsp.hit) ||
					(rsp.read_value !== exp_rsp.read_value) ||
					(rsp.misaligned !== exp_rsp.misaligned) ||
					(rsp.bytes_total !== exp_rsp.bytes_total);
				if (bad) begin
					err_count++;
					if (err_count <= 10)
						$display("rsp %0d: exp %0b %h %0b %0d, got %0b %h %0b %0d",
							rsp_count, exp_rsp.hit, exp_rsp.read_value,
							exp_rsp.misaligned, exp_rsp.bytes_total, rsp.hit,
							rsp.read_value, rsp.misaligned, rsp.bytes_total);
				end
			end
		end
	end

	initial begin : stimulus
		salrc_pkg::cache_req_t item;
		salrc_pkg::cache_rsp_t none;
		logic [1:0]            kind;
		logic [5:0]            blk;
		logic [2:0]            off, amask;
		int                    i;

		for (i = 0; i < LINES; i++) begin
			line_valid[i] = 1'b0;
			line_tag[i]   = 0;
			line_stamp[i] = '0;
			line_data[i]  = '0;
		end
		for (i = 0; i < MEM_DEPTH; i++)
			mem_image[i] = '0;
		access_clock = '0;
		byte_count   = '0;
		none         = '0;

		// misaligned reads and loads right after reset
		add_row(salrc_pkg::REQ_HALF, 1,   32'h0,        1, 0, 32'h0,        1, 0);
		add_row(salrc_pkg::REQ_WORD, 511, 32'h0,        1, 0, 32'h0,        1, 0);
		add_row(salrc_pkg::REQ_WORD, 2,   32'h0,        1, 0, 32'h0,        1, 0);
		add_row(salrc_pkg::REQ_LOAD, 0,   32'h807FFF80, 1, 0, 32'h0,        0, 0);
		add_row(salrc_pkg::REQ_LOAD, 4,   32'hDEADBEEF, 1, 0, 32'h0,        0, 0);
		add_row(salrc_pkg::REQ_LOAD, 505, 32'h7FFFFFFF, 1, 0, 32'h0,        0, 0);
		add_row(salrc_pkg::REQ_LOAD, 511, 32'hFFFFFFFF, 1, 0, 32'h0,        0, 0);
		// sign extension at both ends of the address range
		add_row(salrc_pkg::REQ_BYTE, 0,   32'h0,        1, 0, 32'hFFFFFF80, 0, 1);
		add_row(salrc_pkg::REQ_BYTE, 1,   32'h0,        1, 1, 32'hFFFFFFFF, 0, 2);
		add_row(salrc_pkg::REQ_HALF, 2,   32'h0,        0, 0, 32'h0,        0, 0);
		add_row(salrc_pkg::REQ_WORD, 4,   32'h0,        1, 1, 32'hDEADBEEF, 0, 8);
		add_row(salrc_pkg::REQ_HALF, 6,   32'h0,        0, 0, 32'h0,        0, 0);
		add_row(salrc_pkg::REQ_BYTE, 511, 32'h0,        1, 0, 32'hFFFFFFFF, 0, 11);
		add_row(salrc_pkg::REQ_WORD, 504, 32'h0,        1, 1, 32'h7FFFFFFF, 0, 15);
		add_row(salrc_pkg::REQ_HALF, 510, 32'h0,        0, 0, 32'h0,        0, 0);
		add_row(salrc_pkg::REQ_HALF, 3,   32'h0,        0, 0, 32'h0,        0, 0);
		// load over a cached line: the line keeps its old copy
		add_row(salrc_pkg::REQ_LOAD, 0,   32'h00000001, 0, 0, 32'h0,        0, 0);
		add_row(salrc_pkg::REQ_LOAD, 32,  32'h11223344, 0, 0, 32'h0,        0, 0);
		add_row(salrc_pkg::REQ_LOAD, 36,  32'h55667788, 0, 0, 32'h0,        0, 0);
		add_row(salrc_pkg::REQ_LOAD, 64,  32'h0000007F, 0, 0, 32'h0,        0, 0);
		add_row(salrc_pkg::REQ_LOAD, 68,  32'h80000000, 0, 0, 32'h0,        0, 0);
		add_row(salrc_pkg::REQ_BYTE, 0,   32'h0,        0, 0, 32'h0,        0, 0);
		// three blocks in set 0: fill the second way, then evict the oldest
		add_row(salrc_pkg::REQ_WORD, 32,  32'h0,        0, 0, 32'h0,        0, 0);
		add_row(salrc_pkg::REQ_BYTE, 64,  32'h0,        0, 0, 32'h0,        0, 0);
		add_row(salrc_pkg::REQ_WORD, 68,  32'h0,        0, 0, 32'h0,        0, 0);
		add_row(salrc_pkg::REQ_BYTE, 0,   32'h0,        0, 0, 32'h0,        0, 0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[i])
			send_req(stim_rows[i].rq, stim_rows[i].typed, stim_rows[i].rsp);

		// write every memory word so that no fill reads an unwritten word
		for (i = 0; i < MEM_DEPTH; i++) begin
			item.req_type  = salrc_pkg::REQ_LOAD;
			item.address   = salrc_pkg::ADDR_W'(i * 4 + $urandom_range(0, 3));
			item.load_word = $urandom;
			send_req(item, 1'b0, none);
		end

		for (i = 0; i < RANDOM_REQS; i++) begin
			if ($urandom_range(0, 99) < 15) begin
				item.req_type  = salrc_pkg::REQ_LOAD;
				item.address   = salrc_pkg::ADDR_W'($urandom_range(0, 511));
				item.load_word = $urandom;
			end else begin
				kind = 2'($urandom_range(1, 3));
				// mostly a few conflicting blocks per set to drive hits and evictions
				if ($urandom_range(0, 99) < 60)
					blk = 6'($urandom_range(0, SETS - 1) + SETS * $urandom_range(0, 2));
				else
					blk = 6'($urandom_range(0, 63));
				off   = 3'($urandom_range(0, 7));
				amask = (kind == salrc_pkg::REQ_WORD) ? 3'b011 :
					(kind == salrc_pkg::REQ_HALF) ? 3'b001 : 3'b000;
				if ($urandom_range(0, 99) < 85)
					off = off & ~amask;
				item.req_type  = kind;
				item.address   = {blk, off};
				item.load_word = $urandom;
			end
			send_req(item, 1'b0, none);
		end
		req_valid <= 1'b0;

		while (owed_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (err_count == 0 && owed_rsp.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
